// ===== design/sadm_pkg.sv =====
// ----------------------------------------------------------------------------
// sadm_pkg
// Shared constants, control types and helpers for the arcade drive mixer.
// ----------------------------------------------------------------------------
package sadm_pkg;

   localparam int SADM_HISTORY_LIMIT = 25;
   localparam int SAMPLE_W           = 16;
   localparam int DEADBAND_W         = 15;
   localparam int MIX_W              = 17;

   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd1311;

   // request codes
   localparam logic CMD_TELEOP  = 1'b0;
   localparam logic CMD_DISABLE = 1'b1;

   // edge count codes
   localparam logic [1:0] MODE_DIRECT = 2'd0;
   localparam logic [1:0] MODE_MEAN   = 2'd2;
   localparam logic [1:0] VALVE_OPEN  = 2'd0;
   localparam logic [1:0] VALVE_CLOSE = 2'd2;

   localparam logic [SAMPLE_W-1:0] SQ_MAX = 16'd32767;

   typedef struct packed {
      logic load;     // take the request, push history, step buttons
      logic clear;    // disabled tick: empty the history
      logic prep;     // drop oldest, start mean, steering deadband
      logic sq_ang;   // square steering
      logic sq_pow;   // square throttle
      logic mix;      // load result registers
   } ctrl_cmd_type;

   typedef struct packed {
      logic mean_mode;
      logic div_busy;
   } ctrl_stat_type;

   function automatic logic signed [MIX_W-1:0] smax(input logic signed [MIX_W-1:0] a,
                                                   input logic signed [MIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== design/sadm_div.sv =====
// ----------------------------------------------------------------------------
// sadm_div
// Restoring divider for the history mean, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sadm_div import sadm_pkg::*; #(
   parameter int TW = 21,
   parameter int FW = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [TW-1:0]       dividend,
   input  logic [FW-1:0]              divisor,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] quotient
);

   localparam int CW = $clog2(TW + 1);

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [TW-1:0]  quo_ff, quo_in;
   logic [FW-1:0]  rem_ff, rem_in;
   logic [FW-1:0]  dsr_ff, dsr_in;
   logic           neg_ff, neg_in;
   logic [FW:0]    trial;
   logic [TW-1:0]  mag;

   assign mag   = dividend[TW-1] ? TW'(-dividend) : TW'(dividend);
   assign trial = {rem_ff, quo_ff[TW-1]};

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      if (start) begin
         cnt_in = CW'(TW);
         quo_in = mag;
         rem_in = '0;
         dsr_in = divisor;
         neg_in = dividend[TW-1];
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = FW'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[TW-2:0], 1'b1};
         end else begin
            rem_in = trial[FW-1:0];
            quo_in = {quo_ff[TW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign busy     = (cnt_ff != '0);
   // mean magnitude never exceeds 32768, so the low bits hold it exactly
   assign quotient = neg_ff ? SAMPLE_W'(-quo_ff[SAMPLE_W-1:0]) : quo_ff[SAMPLE_W-1:0];

endmodule

// ===== design/sadm_datapath.sv =====
// ----------------------------------------------------------------------------
// sadm_datapath
// History ring, button edge counters, squaring, mixing and result registers.
// ----------------------------------------------------------------------------
module sadm_datapath import sadm_pkg::*; #(
   parameter int HISTORY_LIMIT = SADM_HISTORY_LIMIT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_cmd_type                 cmd,
   output ctrl_stat_type                stat,
   input  logic signed [SAMPLE_W-1:0]   req_throttle_sample,
   input  logic signed [SAMPLE_W-1:0]   req_steer_sample,
   input  logic                         req_button_a,
   input  logic                         req_button_b,
   input  logic                         csr_we,
   input  logic [DEADBAND_W-1:0]        csr_steer_deadband,
   output logic signed [SAMPLE_W-1:0]   rsp_left_drive,
   output logic signed [SAMPLE_W-1:0]   rsp_right_drive,
   output logic                         rsp_valve_on
);

   localparam int DEPTH = HISTORY_LIMIT + 1;
   localparam int IW    = $clog2(DEPTH);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int TW    = $clog2(DEPTH) + SAMPLE_W;

   logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];

   logic [DEADBAND_W-1:0]      deadband_ff;
   logic signed [SAMPLE_W-1:0] thr_ff, steer_ff, rd_ff, ang_ff, ang_in;
   logic [1:0]                 valve_cnt_ff, valve_cnt_in, mode_cnt_ff, mode_cnt_in;
   logic                       prev_a_ff, prev_b_ff, valve_ff, valve_in;
   logic [IW-1:0]              head_ff, head_in;
   logic [FW-1:0]              fill_ff;
   logic signed [TW-1:0]       total_ff;
   logic signed [MIX_W-1:0]    a_ff, t_ff, sq_res;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff, left_in, right_in;
   logic                       valve_out_ff;

   logic                       div_start, div_busy;
   logic signed [SAMPLE_W-1:0] div_q, power, sq_src, ang_neg;
   logic [SAMPLE_W-1:0]        sq_mag, ang_mag;
   logic [2*SAMPLE_W-1:0]      prod;
   logic [SAMPLE_W:0]          prod_sh;
   logic [SAMPLE_W-1:0]        sq_sat;
   logic signed [MIX_W-1:0]    lo, ro, na, ro_neg;

   // ---- button edge counters ----
   always_comb begin
      valve_cnt_in = valve_cnt_ff + 2'((req_button_a != prev_a_ff) ? 1 : 0);
      mode_cnt_in  = mode_cnt_ff  + 2'((req_button_b != prev_b_ff) ? 1 : 0);
      valve_in     = valve_ff;
      if (valve_cnt_in == VALVE_OPEN) begin
         valve_in = 1'b1;
      end else if (valve_cnt_in == VALVE_CLOSE) begin
         valve_in = 1'b0;
      end
   end

   assign head_in = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // ---- steering: negate with saturation, then deadband ----
   always_comb begin
      ang_neg = (steer_ff == {1'b1, {(SAMPLE_W-1){1'b0}}}) ? SQ_MAX : SAMPLE_W'(-steer_ff);
      ang_mag = ang_neg[SAMPLE_W-1] ? SAMPLE_W'(-ang_neg) : ang_neg;
      ang_in  = (ang_mag < {1'b0, deadband_ff}) ? '0 : ang_neg;
   end

   assign div_start      = cmd.prep && (mode_cnt_ff == MODE_MEAN);
   assign stat.mean_mode = (mode_cnt_ff == MODE_MEAN);
   assign stat.div_busy  = div_busy;

   sadm_div #(.TW(TW), .FW(FW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (fill_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // ---- shared squarer ----
   always_comb begin
      case (mode_cnt_ff)
         MODE_DIRECT: power = thr_ff;
         MODE_MEAN:   power = div_q;
         default:     power = '0;
      endcase
      sq_src  = cmd.sq_ang ? ang_ff : power;
      sq_mag  = sq_src[SAMPLE_W-1] ? SAMPLE_W'(-sq_src) : sq_src;
      prod    = sq_mag * sq_mag;
      prod_sh = prod[2*SAMPLE_W-1:SAMPLE_W-1];
      sq_sat  = (prod_sh > {1'b0, SQ_MAX}) ? SQ_MAX : prod_sh[SAMPLE_W-1:0];
      sq_res  = sq_src[SAMPLE_W-1] ? -$signed({1'b0, sq_sat}) : $signed({1'b0, sq_sat});
   end

   // ---- arcade mixing ----
   always_comb begin
      na = -a_ff;
      if (t_ff > 0) begin
         if (na < 0) begin
            lo = t_ff + na;
            ro = smax(t_ff, -na);
         end else begin
            lo = smax(t_ff, na);
            ro = t_ff - na;
         end
      end else begin
         if (a_ff > 0) begin
            lo = -smax(-t_ff, a_ff);
            ro = t_ff + a_ff;
         end else begin
            lo = t_ff - a_ff;
            ro = -smax(-t_ff, -a_ff);
         end
      end
      ro_neg   = -ro;
      left_in  = lo[SAMPLE_W-1:0];
      right_in = ro_neg[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hist_mem[head_ff] <= req_throttle_sample;
      end
      rd_ff <= hist_mem[head_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RESET;
         valve_cnt_ff <= '0;
         mode_cnt_ff  <= '0;
         prev_a_ff    <= 1'b0;
         prev_b_ff    <= 1'b0;
         valve_ff     <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
      end else begin
         if (csr_we) begin
            deadband_ff <= csr_steer_deadband;
         end
         if (cmd.clear) begin
            head_ff  <= '0;
            fill_ff  <= '0;
            total_ff <= '0;
         end else if (cmd.load) begin
            valve_cnt_ff <= valve_cnt_in;
            mode_cnt_ff  <= mode_cnt_in;
            prev_a_ff    <= req_button_a;
            prev_b_ff    <= req_button_b;
            valve_ff     <= valve_in;
            head_ff      <= head_in;
            fill_ff      <= fill_ff + 1'b1;
            total_ff     <= total_ff + {{(TW-SAMPLE_W){req_throttle_sample[SAMPLE_W-1]}},
                                        req_throttle_sample};
         end else if (cmd.prep && (fill_ff == FW'(DEPTH))) begin
            // ring full: oldest entry sits at the next write slot
            fill_ff  <= fill_ff - 1'b1;
            total_ff <= total_ff - {{(TW-SAMPLE_W){rd_ff[SAMPLE_W-1]}}, rd_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         thr_ff   <= req_throttle_sample;
         steer_ff <= req_steer_sample;
      end
      if (cmd.prep) begin
         ang_ff <= ang_in;
      end
      if (cmd.sq_ang) begin
         a_ff <= sq_res;
      end
      if (cmd.sq_pow) begin
         t_ff <= sq_res;
      end
      if (cmd.mix) begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         valve_out_ff <= valve_ff;
      end
   end

   assign rsp_left_drive  = left_ff;
   assign rsp_right_drive = right_ff;
   assign rsp_valve_on    = valve_out_ff;

endmodule

// ===== design/sadm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sadm_ctrl
// Sequencer: steps one request through the datapath, owns the handshakes.
// ----------------------------------------------------------------------------
module sadm_ctrl import sadm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_cmd,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  ctrl_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_SQA,
      S_SQT,
      S_MIX
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_DISABLE) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.mean_mode ? S_DIV : S_SQA;
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               state_in = S_SQA;
            end
         end
         S_SQA: begin
            cmd.sq_ang = 1'b1;
            state_in   = S_SQT;
         end
         S_SQT: begin
            cmd.sq_pow = 1'b1;
            state_in   = S_MIX;
         end
         S_MIX: begin
            if (out_free) begin
               cmd.mix      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/smoothed_arcade_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// smoothed_arcade_drive_mixer
// Arcade drive mixer with squared inputs, throttle smoothing and valve toggle.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one request per control tick: cmd, throttle and steering
//    samples (Q1.15) and two button levels. cmd = disabled empties the
//    throttle history in the cycle it is taken and gives no response.
//  - rsp_* returns one response per teleop request: left and right drive
//    (right already negated) and the valve level.
//  - csr_* writes the steering deadband; always ready, write only when idle.
// Timing and flow:
//  - rsp_valid rises once a teleop request has stepped through prep, the
//    steering and throttle squaring and the mix; in mean mode the history
//    divider runs after prep, one quotient bit per cycle over the TW-bit total.
//  - One request at a time: req_ready is high again the cycle after the
//    response is loaded.
//  - The response register parts the two sides, so a new request is taken
//    while an old response waits; a stalled receiver only holds the next
//    response in the final step until the register frees.
// Reset: counters, button history, valve and history fill clear; deadband
//  returns to 1311. History storage is not cleared (only written slots read).
// ----------------------------------------------------------------------------
module smoothed_arcade_drive_mixer import sadm_pkg::*; #(
   parameter int HISTORY_LIMIT = SADM_HISTORY_LIMIT
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic signed [SAMPLE_W-1:0]  req_throttle_sample,
   input  logic signed [SAMPLE_W-1:0]  req_steer_sample,
   input  logic                        req_button_a,
   input  logic                        req_button_b,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_left_drive,
   output logic signed [SAMPLE_W-1:0]  rsp_right_drive,
   output logic                        rsp_valve_on,
   // deadband register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [DEADBAND_W-1:0]       csr_steer_deadband
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // register write never stalls
   assign csr_ready = 1'b1;

   // sequencer: handshakes and step order
   sadm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: history ring, mean divider, squarer, mixer
   sadm_datapath #(.HISTORY_LIMIT(HISTORY_LIMIT)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_throttle_sample (req_throttle_sample),
      .req_steer_sample    (req_steer_sample),
      .req_button_a        (req_button_a),
      .req_button_b        (req_button_b),
      .csr_we              (csr_valid && csr_ready),
      .csr_steer_deadband  (csr_steer_deadband),
      .rsp_left_drive      (rsp_left_drive),
      .rsp_right_drive     (rsp_right_drive),
      .rsp_valve_on        (rsp_valve_on)
   );

endmodule

// ===== dv/tb_smoothed_arcade_drive_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_smoothed_arcade_drive_mixer
// Self-checking bench for the arcade drive mixer. A short table of directed
// requests covers the extremes, deadband edges, valve and mode wrap and the
// disabled tick. Five randomised phases follow, each under its own steering
// deadband. Each response is checked against its typed row or a cycle-free
// model of the mixer. The sender runs in bursts; the receiver stalls to a pattern.
// ----------------------------------------------------------------------------
module tb_smoothed_arcade_drive_mixer import sadm_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH      = SADM_HISTORY_LIMIT + 1;
   localparam int DIRECTED_ROWS   = 23;
   localparam int PHASES          = 5;
   localparam int PHASE_TICKS     = 390;
   // SETTLE_CYCLES of idle time cover any request still being worked on once
   // the last response is in
   localparam int SETTLE_CYCLES   = 40;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AFTER      = 400;
   // slowest honest gap between handshakes is the long hold plus one mean
   // mode request, a sender gap and a receiver stall; allow about eight times that
   localparam int WATCHDOG_CYCLES = 3000;

   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] throttle;
      logic signed [SAMPLE_W-1:0] steer;
      logic                       button_a;
      logic                       button_b;
   } tick_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       valve;
   } drive_type;

   typedef struct packed {
      tick_type  tick;
      logic      typed;   // 1: want holds the response, 0: use the model
      drive_type want;
   } directed_row_type;

   localparam drive_type NO_WANT = '0;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_CORNERS [6] = '{
      16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
   };

   // Directed requests. Typed responses assume reset state with the deadband
   // at its reset value of 1311 and both buttons released.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      //   cmd           throttle     steer        a     b      typed  response
      // idle sticks after reset: valve energised straight away
      '{'{CMD_TELEOP,  16'sd0,      16'sd0,      1'b0, 1'b0}, 1'b1,
        '{16'sd0,      16'sd0,      1'b1}},
      // full forward / full reverse throttle, reverse squares to saturation
      '{'{CMD_TELEOP,  16'sd32767,  16'sd0,      1'b0, 1'b0}, 1'b1,
        '{16'sd32766, -16'sd32766,  1'b1}},
      '{'{CMD_TELEOP,  16'sh8000,   16'sd0,      1'b0, 1'b0}, 1'b1,
        '{-16'sd32767, 16'sd32767,  1'b1}},
      // steering extremes, most negative saturates on negation
      '{'{CMD_TELEOP,  16'sd0,      16'sh8000,   1'b0, 1'b0}, 1'b1,
        '{-16'sd32766, -16'sd32766, 1'b1}},
      '{'{CMD_TELEOP,  16'sd0,      16'sd32767,  1'b0, 1'b0}, 1'b1,
        '{16'sd32766,  16'sd32766,  1'b1}},
      // just inside and just on the deadband
      '{'{CMD_TELEOP,  16'sd0,      16'sd1310,   1'b0, 1'b0}, 1'b1,
        '{16'sd0,      16'sd0,      1'b1}},
      '{'{CMD_TELEOP,  16'sd0,      16'sd1311,   1'b0, 1'b0}, 1'b1,
        '{16'sd52,     16'sd52,     1'b1}},
      // both sticks hard over at once
      '{'{CMD_TELEOP,  16'sd32767,  16'sh8000,   1'b0, 1'b0}, 1'b1,
        '{16'sd0,     -16'sd32766,  1'b1}},
      '{'{CMD_TELEOP,  16'sh8000,   16'sd32767,  1'b0, 1'b0}, 1'b1,
        '{-16'sd1,     16'sd32767,  1'b1}},
      // valve count steps 1, 2, 3 and wraps to 0
      '{'{CMD_TELEOP,  16'sd12000, -16'sd5000,   1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP, -16'sd9000,   16'sd7000,   1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP,  16'sd4000,   16'sd0,      1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP, -16'sd4000,  -16'sd1311,   1'b0, 1'b0}, 1'b0, NO_WANT},
      // disabled tick: no response, buttons ignored
      '{'{CMD_DISABLE, 16'sd32767,  16'sh8000,   1'b1, 1'b1}, 1'b0, NO_WANT},
      // odd mode gives zero throttle, then mean mode over a fresh history
      '{'{CMD_TELEOP,  16'sd20000,  16'sd3000,   1'b0, 1'b1}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP, -16'sd20000, -16'sd3000,   1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP,  16'sd32767,  16'sd0,      1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_DISABLE, 16'sd0,      16'sd0,      1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP,  16'sh8000,   16'sd2000,   1'b0, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP, -16'sd32767, -16'sd2000,   1'b0, 1'b0}, 1'b0, NO_WANT},
      // mode 3 then wrap back to direct
      '{'{CMD_TELEOP,  16'sd1,      16'sd1,      1'b1, 1'b1}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP, -16'sd1,     -16'sd1,      1'b1, 1'b0}, 1'b0, NO_WANT},
      '{'{CMD_TELEOP,  16'sh8000,   16'sh8000,   1'b1, 1'b0}, 1'b0, NO_WANT}
   };

   // ------------------------------------------------------------------------
   // clock, reset and block ports
   // ------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_cmd = CMD_TELEOP;
   logic signed [SAMPLE_W-1:0] req_throttle_sample = '0;
   logic signed [SAMPLE_W-1:0] req_steer_sample = '0;
   logic                       req_button_a = 1'b0;
   logic                       req_button_b = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_drive;
   logic signed [SAMPLE_W-1:0] rsp_right_drive;
   logic                       rsp_valve_on;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [DEADBAND_W-1:0]      csr_steer_deadband = '0;

   // half period of 1 ns gives the 2 ns clock
   always #1 clock = ~clock;

   smoothed_arcade_drive_mixer i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_throttle_sample (req_throttle_sample),
      .req_steer_sample    (req_steer_sample),
      .req_button_a        (req_button_a),
      .req_button_b        (req_button_b),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_drive      (rsp_left_drive),
      .rsp_right_drive     (rsp_right_drive),
      .rsp_valve_on        (rsp_valve_on),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_steer_deadband  (csr_steer_deadband)
   );

   // ------------------------------------------------------------------------
   // mixer model state: our own copy of everything the block remembers
   // ------------------------------------------------------------------------
   logic [DEADBAND_W-1:0]      deadband_q    = DEADBAND_RESET;
   logic [1:0]                 valve_count_q = '0;
   logic [1:0]                 mode_count_q  = '0;
   logic                       last_a_q      = 1'b0;
   logic                       last_b_q      = 1'b0;
   logic                       valve_q       = 1'b0;
   logic signed [SAMPLE_W-1:0] thr_ring [HIST_DEPTH];
   int                         ring_fill = 0;
   int                         ring_head = 0;
   int                         ring_sum  = 0;

   drive_type pending_drive [$];   // responses owed by the block, oldest first

   int tick_count         = 0;
   int disabled_count     = 0;
   int mean_ticks         = 0;
   int full_history_ticks = 0;
   int drive_checked      = 0;
   int mismatch_count     = 0;
   int burst_left         = 0;

   function automatic int larger(input int x, input int y);
      return (x > y) ? x : y;
   endfunction

   // magnitude squared in Q1.15, truncated and clipped, sign put back
   function automatic int square_keep_sign(input int x);
      int m;
      int s;
      m = (x < 0) ? -x : x;
      s = (m * m) >> 15;
      if (s > 32767) s = 32767;
      return (x < 0) ? -s : s;
   endfunction

   // Advances the model by one request; has_drive is low for disabled ticks.
   task automatic mix_tick(input tick_type t, output bit has_drive, output drive_type d);
      int thr;
      int st;
      int power;
      int ang;
      int mag;
      int a;
      int p;
      int lo;
      int ro;
      has_drive = 1'b0;
      d         = NO_WANT;
      tick_count++;
      if (t.cmd == CMD_DISABLE) begin
         // history emptied; button levels and counts left alone
         ring_fill = 0;
         ring_head = 0;
         ring_sum  = 0;
         disabled_count++;
         return;
      end
      thr = $signed(t.throttle);
      st  = $signed(t.steer);

      // any level change steps the count, wrapping modulo 4
      if (t.button_a != last_a_q) valve_count_q = valve_count_q + 2'd1;
      last_a_q = t.button_a;
      if (valve_count_q == VALVE_OPEN) valve_q = 1'b1;
      else if (valve_count_q == VALVE_CLOSE) valve_q = 1'b0;
      if (t.button_b != last_b_q) mode_count_q = mode_count_q + 2'd1;
      last_b_q = t.button_b;

      // newest sample goes in before the mean is taken
      thr_ring[ring_head] = t.throttle;
      ring_head = (ring_head + 1) % HIST_DEPTH;
      ring_fill++;
      ring_sum += thr;

      if (mode_count_q == MODE_DIRECT) begin
         power = thr;
      end else if (mode_count_q == MODE_MEAN) begin
         power = ring_sum / ring_fill;   // truncates toward zero
         mean_ticks++;
      end else begin
         power = 0;
      end

      // oldest drops out only after the mean, so the mean spans limit+1
      if (ring_fill > SADM_HISTORY_LIMIT) begin
         ring_sum -= thr_ring[(ring_head + HIST_DEPTH - ring_fill) % HIST_DEPTH];
         ring_fill--;
         full_history_ticks++;
      end

      ang = (st == -32768) ? 32767 : -st;
      mag = (ang < 0) ? -ang : ang;
      if (mag < int'(deadband_q)) ang = 0;

      a = square_keep_sign(ang);
      p = square_keep_sign(power);

      // arcade mixing by quadrant
      if (p > 0) begin
         a = -a;
         if (a < 0) begin
            lo = p + a;
            ro = larger(p, -a);
         end else begin
            lo = larger(p, a);
            ro = p - a;
         end
      end else begin
         if (a > 0) begin
            lo = -larger(-p, a);
            ro = p + a;
         end else begin
            lo = p - a;
            ro = -larger(-p, -a);
         end
      end

      has_drive = 1'b1;
      d.left    = 16'(lo);
      d.right   = 16'(-ro);   // right side is mounted mirrored
      d.valve   = valve_q;
   endtask

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------

   // Burst pacing: within a burst requests go back to back, between bursts
   // valid drops for a random gap.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
   endtask

   // Offers one request, waits for it to be taken, then books the response.
   task automatic offer_tick(input tick_type t, input logic typed, input drive_type want);
      bit        has_drive;
      drive_type d;
      req_valid           <= 1'b1;
      req_cmd             <= t.cmd;
      req_throttle_sample <= t.throttle;
      req_steer_sample    <= t.steer;
      req_button_a        <= t.button_a;
      req_button_b        <= t.button_b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      mix_tick(t, has_drive, d);
      if (has_drive) pending_drive.push_back(typed ? want : d);
      pace_sender();
   endtask

   // Idle the request side until every response is back, then allow for a
   // disabled tick still in flight.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_deadband(input logic [DEADBAND_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_steer_deadband <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      deadband_q  = value;
   endtask

   initial begin : stimulus
      tick_type              t;
      logic [DEADBAND_W-1:0] deadband_next;
      logic                  level_a;
      logic                  level_b;
      int                    near;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);

      // buttons continue from where the directed rows left them
      level_a = DIRECTED[DIRECTED_ROWS-1].tick.button_a;
      level_b = DIRECTED[DIRECTED_ROWS-1].tick.button_b;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       deadband_next = '0;            // no deadband at all
            1:       deadband_next = '1;            // only full deflection passes
            2:       deadband_next = DEADBAND_W'($urandom_range(0, 32767));
            3:       deadband_next = DEADBAND_RESET;
            default: deadband_next = DEADBAND_W'($urandom_range(0, 3000));
         endcase
         settle_block();
         write_deadband(deadband_next);

         for (int n = 0; n < PHASE_TICKS; n++) begin
            // valve button changes often, mode button rarely, so a mode usually
            // holds long enough for the history to fill past its limit
            if ($urandom_range(0, 5) == 0) level_a = ~level_a;
            if ($urandom_range(0, 39) == 0) level_b = ~level_b;
            t.cmd      = ($urandom_range(0, 39) == 0) ? CMD_DISABLE : CMD_TELEOP;
            t.button_a = level_a;
            t.button_b = level_b;
            case ($urandom_range(0, 3))
               0:       t.throttle = SAMPLE_CORNERS[$urandom_range(0, 5)];
               1:       t.throttle = 16'(int'($urandom_range(0, 4000)) - 2000);
               default: t.throttle = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: t.steer = SAMPLE_CORNERS[$urandom_range(0, 5)];
               1: begin
                  // straddle the deadband on either side of centre
                  near    = int'(deadband_q) + int'($urandom_range(0, 2)) - 1;
                  t.steer = ($urandom_range(0, 1) == 0) ? 16'(near) : 16'(-near);
               end
               default: t.steer = 16'($urandom);
            endcase
            offer_tick(t, 1'b0, NO_WANT);
         end
      end

      settle_block();
      $display("Run covered %0d requests (%0d disabled), %0d responses checked.",
               tick_count, disabled_count, drive_checked);
      $display("Mean mode on %0d requests, full history on %0d, %0d deadband settings.",
               mean_ticks, full_history_ticks, PHASES + 1);
      if (mismatch_count == 0 && pending_drive.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver side: rotating stall styles plus one long hold-off that backs
   // the block up until it refuses requests
   // ------------------------------------------------------------------------
   initial begin : receiver
      int rx_cycle;
      bit held_off;
      rx_cycle = 0;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (!held_off && drive_checked >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held_off = 1'b1;
         end
         case ((rx_cycle / 89) % 4)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 2) != 0);
            2:       rsp_ready <= (rx_cycle % 5 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------
   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : drive_monitor
      drive_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                     $time, rsp_left_drive, rsp_right_drive, rsp_valve_on);
         end else begin
            want = pending_drive.pop_front();
            check_field("left_drive", want.left, rsp_left_drive);
            check_field("right_drive", want.right, rsp_right_drive);
            check_field("valve_on", want.valve, rsp_valve_on);
            drive_checked++;
         end
      end
   end

   // Ends the run if no handshake of any kind completes for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("TB_ERROR");
      $finish;
   end

endmodule
